>>> hw/rtl/set_assoc_cache_tag_lookup_defines.svh
// Assertion macros for the cache tag lookup block.
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SACTL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SACTL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/sactl_pkg.sv
`default_nettype none

package sactl_pkg;

	// Default geometry
	localparam int DEF_LINES     = 1024;
	localparam int DEF_ADDR_BITS = 32;
	localparam int DEF_MAX_WAYS  = 8;

	// Fixed field widths
	localparam int IN_W        = 32;
	localparam int CNT_W       = 32;
	localparam int WAYS_LOG2_W = 2;

	// Configuration port
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS_LOG2 = 1'b0;

	// Lookup sequencer states
	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_RD    = 5'b00100,
		ST_CMP   = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

endpackage

`default_nettype wire

>>> hw/rtl/set_assoc_cache_tag_lookup.sv
// Each lookup runs ST_RD and ST_CMP per way examined, then ST_FIN registers the result
// (one tag memory read and one compare per way; the scan stops at the first hit).
// ST_FIN waits while out_stall holds a result; in_stall stays high until ST_IDLE.
// Reset: counters and associativity clear at once; then a clearing pass writes all
// LINES tag entries invalid, one per cycle, with in_stall high.
`default_nettype none

`include "set_assoc_cache_tag_lookup_defines.svh"

module set_assoc_cache_tag_lookup
	import sactl_pkg::*;
#(
	parameter int LINES     = DEF_LINES,
	parameter int ADDR_BITS = DEF_ADDR_BITS,
	parameter int MAX_WAYS  = DEF_MAX_WAYS
) (
	input  wire                    clk,
	input  wire                    arst_n,
	// configuration port
	input  wire                    psel,
	input  wire                    penable,
	input  wire                    pwrite,
	input  wire [CFG_ADDR_W-1:0]   paddr,
	input  wire [CFG_DATA_W-1:0]   pwdata,
	output logic [CFG_DATA_W-1:0]  prdata,
	output logic                   pready,
	// input channel
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire [IN_W-1:0]         block_address,
	// output channel
	output logic                   out_valid,
	input  wire                    out_stall,
	output logic                   is_hit,
	output logic [CNT_W-1:0]       hit_total,
	output logic [CNT_W-1:0]       miss_total
);

	localparam int IDX_W  = $clog2(LINES);
	localparam int AW     = (ADDR_BITS < IN_W) ? ADDR_BITS : IN_W;
	localparam int MAX_WL = $clog2(MAX_WAYS + 1) - 1;
	localparam int CAP_WL = (MAX_WL < 3) ? MAX_WL : 3;
	localparam int WAY_W  = (CAP_WL > 0) ? CAP_WL : 1;
	localparam int TAG_W  = AW - (IDX_W - CAP_WL);
	localparam logic [WAYS_LOG2_W-1:0] WL_CAP = WAYS_LOG2_W'(CAP_WL);

	state_t state_q, state_d;

	logic [WAYS_LOG2_W-1:0] ways_q;
	logic [WAYS_LOG2_W-1:0] wl_eff;
	logic [WAYS_LOG2_W-1:0] wl_q;

	logic [IDX_W-1:0] clr_q;
	logic [IDX_W-1:0] base_q;
	logic [TAG_W-1:0] tag_q;
	logic [WAY_W-1:0] way_q;
	logic [WAY_W-1:0] victim_q;
	logic [WAY_W-1:0] way_last;
	logic             hit_q;
	logic             found_q;

	logic [CNT_W-1:0] hits_q;
	logic [CNT_W-1:0] misses_q;
	logic [CNT_W-1:0] hits_nx;
	logic [CNT_W-1:0] misses_nx;

	logic             out_valid_q;
	logic             is_hit_q;
	logic [CNT_W-1:0] hit_total_q;
	logic [CNT_W-1:0] miss_total_q;

	logic [AW-1:0]    addr_in;
	logic [IDX_W-1:0] base_in;
	logic [AW-1:0]    tag_full;

	logic [TAG_W:0]   mem [LINES];
	logic [TAG_W:0]   rd_data_q;
	logic [IDX_W-1:0] rd_addr;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [TAG_W:0]   mem_wd;

	logic cfg_we;
	logic in_acc;
	logic out_free;
	logic fin_go;
	logic way_hit;

	// Configuration register
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[CFG_ADDR_W-1:2] == REG_WAYS_LOG2);

	always_comb begin
		if (paddr[CFG_ADDR_W-1:2] == REG_WAYS_LOG2) begin
			prdata = CFG_DATA_W'(ways_q);
		end else begin
			prdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_q <= '0;
		end else if (cfg_we) begin
			ways_q <= pwdata[WAYS_LOG2_W-1:0];
		end
	end

	// Clamp associativity to what the geometry allows
	assign wl_eff = (ways_q > WL_CAP) ? WL_CAP : ways_q;

	// Split the address into set base line and tag
	assign addr_in  = block_address[AW-1:0];
	assign base_in  = addr_in[IDX_W-1:0] << wl_eff;
	assign tag_full = (addr_in >> (IDX_W - CAP_WL)) >> (WL_CAP - wl_eff);
	assign way_last = WAY_W'((1 << wl_q) - 1);

	// Handshakes
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign fin_go   = (state_q == ST_FIN) && out_free;

	// Tag memory read and compare
	assign rd_addr = base_q | IDX_W'(way_q);
	assign way_hit = rd_data_q[TAG_W] && (rd_data_q[TAG_W-1:0] == tag_q);

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	// Tag memory write: clearing pass or miss fill
	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_q;
		mem_wd = '0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (fin_go && !hit_q) begin
			mem_we = 1'b1;
			mem_wa = base_q | IDX_W'(victim_q);
			mem_wd = {1'b1, tag_q};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	// Sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == {IDX_W{1'b1}}) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_acc) state_d = ST_RD;
			end
			ST_RD: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (way_hit || way_q == way_last) state_d = ST_FIN;
				else state_d = ST_RD;
			end
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	// Per-item lookup context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			way_q    <= '0;
			hit_q    <= 1'b0;
			found_q  <= 1'b0;
			victim_q <= '0;
			wl_q     <= '0;
		end else if (in_acc) begin
			way_q    <= '0;
			hit_q    <= 1'b0;
			found_q  <= 1'b0;
			victim_q <= '0;
			wl_q     <= wl_eff;
		end else if (state_q == ST_CMP) begin
			if (way_hit) hit_q <= 1'b1;
			if (!rd_data_q[TAG_W] && !found_q) begin
				found_q  <= 1'b1;
				victim_q <= way_q;
			end
			if (!way_hit && way_q != way_last) way_q <= way_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			base_q <= base_in;
			tag_q  <= tag_full[TAG_W-1:0];
		end
	end

	// Saturating totals
	assign hits_nx   = (hits_q == {CNT_W{1'b1}}) ? hits_q : hits_q + 1'b1;
	assign misses_nx = (misses_q == {CNT_W{1'b1}}) ? misses_q : misses_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q   <= '0;
			misses_q <= '0;
		end else if (fin_go) begin
			if (hit_q) hits_q <= hits_nx;
			else misses_q <= misses_nx;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			is_hit_q     <= hit_q;
			hit_total_q  <= hit_q ? hits_nx : hits_q;
			miss_total_q <= hit_q ? misses_q : misses_nx;
		end
	end

	assign out_valid  = out_valid_q;
	assign is_hit     = is_hit_q;
	assign hit_total  = hit_total_q;
	assign miss_total = miss_total_q;

	// Checks
	`SACTL_ASSERT(a_totals_monotonic,
		1'b1 |=> (hits_q >= $past(hits_q)) && (misses_q >= $past(misses_q)),
		"hit or miss total decreased")
	`SACTL_ASSERT(a_result_from_fin,
		$rose(out_valid_q) |-> $past(state_q == ST_FIN),
		"result appeared without a finished lookup")
	`SACTL_ASSERT(a_way_in_range,
		(state_q == ST_RD || state_q == ST_CMP) |-> (way_q <= way_last),
		"way counter ran past the associativity")
	`SACTL_ASSERT_ALWAYS(a_no_accept_in_clear,
		(state_q == ST_CLEAR) |-> in_stall,
		"item accepted during tag clearing pass")

endmodule

`default_nettype wire

>>> tb/sv/set_assoc_cache_tag_lookup_tb.sv
`default_nettype none

module set_assoc_cache_tag_lookup_tb;
	import sactl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_COUNT = DEF_LINES;
	localparam int LINE_BITS  = $clog2(DEF_LINES);
	localparam int MAX_SCAN   = DEF_MAX_WAYS;
	// one past the last defined register, used to check that stray writes are dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 1'b1;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 160;
	localparam int LONG_HOLD     = 300;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		logic             hit;
		logic [CNT_W-1:0] hits;
		logic [CNT_W-1:0] misses;
	} lookup_result_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [IN_W-1:0]       block_address = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  is_hit;
	logic [CNT_W-1:0]      hit_total;
	logic [CNT_W-1:0]      miss_total;

	set_assoc_cache_tag_lookup uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.block_address(block_address),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.is_hit       (is_hit),
		.hit_total    (hit_total),
		.miss_total   (miss_total)
	);

	// Shadow tag store and counters
	logic                    line_ok [LINE_COUNT];
	logic [IN_W-1:0]         line_tag_copy [LINE_COUNT];
	logic [CNT_W-1:0]        hits_seen = '0;
	logic [CNT_W-1:0]        misses_seen = '0;
	logic [WAYS_LOG2_W-1:0]  assoc_log2 = '0;

	logic [IN_W-1:0]  address_queue [$];
	lookup_result_t   expected_lookups [$];
	logic [IN_W-1:0]  recent_addrs [$];

	idle_mode_t idle_mode = IDLE_NONE;
	logic       run_en = 1'b0;
	logic       pressure_go = 1'b0;
	logic       pressure_taken = 1'b0;
	int         hold_left = 0;
	int         err_count = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < LINE_COUNT; i++) begin
			line_ok[i] = 1'b0;
			line_tag_copy[i] = '0;
		end
	end

	// Look up one address in the shadow store, fill on a miss, queue the result
	function automatic void lookup_and_fill(input logic [IN_W-1:0] addr);
		int unsigned     ways;
		int unsigned     set_idx;
		int unsigned     base;
		int unsigned     victim;
		logic [IN_W-1:0] tag_val;
		bit              hit;
		bit              found_free;
		lookup_result_t  res;
		ways = 1 << assoc_log2;
		if (ways > MAX_SCAN)
			ways = MAX_SCAN;
		set_idx = addr & ((LINE_COUNT / ways) - 1);
		tag_val = addr >> (LINE_BITS - $clog2(ways));
		base = set_idx * ways;
		hit = 1'b0;
		found_free = 1'b0;
		victim = 0;
		for (int unsigned w = 0; w < ways; w++) begin
			if (line_ok[base + w] && line_tag_copy[base + w] == tag_val)
				hit = 1'b1;
			if (!line_ok[base + w] && !found_free) begin
				found_free = 1'b1;
				victim = w;
			end
		end
		if (hit) begin
			if (hits_seen != '1)
				hits_seen = hits_seen + 1'b1;
		end else begin
			line_ok[base + victim] = 1'b1;
			line_tag_copy[base + victim] = tag_val;
			if (misses_seen != '1)
				misses_seen = misses_seen + 1'b1;
		end
		res.hit = hit;
		res.hits = hits_seen;
		res.misses = misses_seen;
		expected_lookups.push_back(res);
	endfunction

	// Sender: predict on acceptance, then offer the next address or idle
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			lookup_and_fill(block_address);
		if (!in_valid || !in_stall) begin
			if (run_en && address_queue.size() != 0 &&
			    !((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 47) ||
			      (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 37))) begin
				in_valid <= 1'b1;
				block_address <= address_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: compare each result with the oldest expectation, drive stall
	always @(posedge clk) begin
		lookup_result_t want;
		if (out_valid && !out_stall) begin
			if (expected_lookups.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result is_hit=%0b hit_total=%0d miss_total=%0d",
				         $time, is_hit, hit_total, miss_total);
			end else begin
				want = expected_lookups.pop_front();
				if (is_hit !== want.hit) begin
					err_count++;
					$display("%0t: is_hit expected %0b actual %0b", $time, want.hit, is_hit);
				end
				if (hit_total !== want.hits) begin
					err_count++;
					$display("%0t: hit_total expected %0d actual %0d",
					         $time, want.hits, hit_total);
				end
				if (miss_total !== want.misses) begin
					err_count++;
					$display("%0t: miss_total expected %0d actual %0d",
					         $time, want.misses, miss_total);
				end
			end
		end
		if (pressure_go && !pressure_taken) begin
			pressure_taken <= 1'b1;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (run_en) begin
			out_stall <= (idle_mode == IDLE_RECV && $urandom_range(0, 99) < 47) ||
			             (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 37);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Write one register through the configuration port and mirror it
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_WAYS_LOG2)
			assoc_log2 = value[WAYS_LOG2_W-1:0];
	endtask

	// Mix of revisits, small-tag conflicts and fully random addresses
	task automatic queue_random_addrs(input int count);
		int              pick;
		logic [IN_W-1:0] a;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40 && recent_addrs.size() != 0)
				a = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
			else if (pick < 80)
				a = ($urandom_range(0, 15) << LINE_BITS) | $urandom_range(0, 7);
			else
				a = $urandom();
			address_queue.push_back(a);
			recent_addrs.push_back(a);
			if (recent_addrs.size() > 32)
				void'(recent_addrs.pop_front());
		end
	endtask

	// Let the queued addresses drain and all results arrive
	task automatic drain_phase(input idle_mode_t mode);
		idle_mode <= mode;
		@(posedge clk);
		while (address_queue.size() != 0 || in_valid || expected_lookups.size() != 0)
			@(posedge clk);
		idle_mode <= IDLE_NONE;
		repeat (2 * MAX_SCAN + 4)
			@(posedge clk);
	endtask

	initial begin
		logic [WAYS_LOG2_W-1:0] ways_order [RANDOM_PHASES];
		ways_order = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd1, 2'd0};
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// wait out the clearing pass
		while (in_stall)
			@(posedge clk);
		run_en <= 1'b1;

		// direct mapped: extremes, hits and a conflict eviction
		address_queue.push_back(32'h0000_0000);
		address_queue.push_back(32'h0000_0000);
		address_queue.push_back(32'hFFFF_FFFF);
		address_queue.push_back(32'hFFFF_FFFF);
		address_queue.push_back(32'h0000_0400);
		address_queue.push_back(32'h0000_0000);
		address_queue.push_back(32'hAAAA_AAAA);
		address_queue.push_back(32'h5555_5555);
		address_queue.push_back(32'hAAAA_AAAA);
		drain_phase(IDLE_NONE);

		// a write to an unmapped register leaves the mapping alone
		cfg_write(REG_UNMAPPED, 32'h3);
		address_queue.push_back(32'h0000_0400);
		address_queue.push_back(32'h0000_0000);
		drain_phase(IDLE_NONE);

		// eight ways without flush: fill one set, then overflow it into way 0
		cfg_write(REG_WAYS_LOG2, 32'h3);
		for (int t = 0; t < 9; t++)
			address_queue.push_back((t << (LINE_BITS - 3)) | 5);
		address_queue.push_back(32'h0000_0005);
		address_queue.push_back(32'h0000_0085);
		address_queue.push_back(32'hFFFF_FFFF);
		drain_phase(IDLE_NONE);

		// random phases across associativity and idle patterns
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			cfg_write(REG_WAYS_LOG2, {{(CFG_DATA_W-WAYS_LOG2_W){1'b0}}, ways_order[p]});
			queue_random_addrs(PHASE_ITEMS);
			if (p == 0)
				pressure_go <= 1'b1;
			drain_phase(idle_mode_t'(p % 4));
		end

		repeat (4 * MAX_SCAN)
			@(posedge clk);
		if (err_count == 0 && expected_lookups.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Hard stop
	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
